/* sv/lbp_code_histogram_defines.svh */
// Assertion macros for the LBP code histogram block.
// Used by the top level; the macros expect clk_i and rst_ni in scope.
`ifndef LBP_CODE_HISTOGRAM_DEFINES_SVH
`define LBP_CODE_HISTOGRAM_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define LBP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset
`define LBP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/lbp_pkg.sv */
// Shared types, codes and constants of the LBP code histogram block.
// No dependencies; used by the interface and module files of the block.
`timescale 1ns / 1ps

package lbp_pkg;

  // Field widths of the channels and the configuration port
  localparam int CMD_W       = 2;
  localparam int PIX_W       = 8;
  localparam int BIN_W       = 8;
  localparam int OUT_COUNT_W = 20;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 11;

  // Histogram size and queue depth (power of two)
  localparam int NBINS   = 256;
  localparam int Q_DEPTH = 4;

  // Dimension limits and reset values
  localparam int MIN_DIM    = 3;
  localparam int RST_WIDTH  = 640;
  localparam int RST_HEIGHT = 480;

  // First row / column index at which a window is complete
  localparam int WIN_EDGE = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  // Input commands
  typedef enum logic [CMD_W-1:0] {
    CMD_PIXEL    = 2'd0,
    CMD_READ_BIN = 2'd1,
    CMD_CLEAR    = 2'd2
  } cmd_e;

  // Operations handed from the front to the histogram side
  typedef enum logic [1:0] {
    OP_PIXEL = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // One queued operation: addr is the code for pixels, the bin for reads
  typedef struct packed {
    op_e              op;
    logic             code_valid;
    logic             frame_done;
    logic [BIN_W-1:0] addr;
  } task_t;

  // Queue status seen by the front
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Form the 8-neighbour code: bit set when the neighbour is at least the centre
  function automatic logic [BIN_W-1:0] form_code(
    input logic [PIX_W-1:0] tl, input logic [PIX_W-1:0] t,  input logic [PIX_W-1:0] tr,
    input logic [PIX_W-1:0] l,  input logic [PIX_W-1:0] c,  input logic [PIX_W-1:0] r,
    input logic [PIX_W-1:0] bl, input logic [PIX_W-1:0] b,  input logic [PIX_W-1:0] br
  );
    logic [BIN_W-1:0] code;
    code[0] = (tl >= c);
    code[1] = (t  >= c);
    code[2] = (tr >= c);
    code[3] = (r  >= c);
    code[4] = (br >= c);
    code[5] = (b  >= c);
    code[6] = (bl >= c);
    code[7] = (l  >= c);
    return code;
  endfunction

endpackage

/* sv/lbp_stream_if.sv */
// Valid/ready channel interfaces of the LBP code histogram block.
// Depends on lbp_pkg for the payload widths.
`timescale 1ns / 1ps

// Input items: command, pixel and bin index
interface lbp_in_if;
  logic                        valid;
  logic                        ready;
  logic [lbp_pkg::CMD_W-1:0]   command;
  logic [lbp_pkg::PIX_W-1:0]   pixel;
  logic [lbp_pkg::BIN_W-1:0]   bin_index;

  modport source (output valid, command, pixel, bin_index, input ready);
  modport sink   (input valid, command, pixel, bin_index, output ready);
endinterface

// Result items: code flag, code, end of frame and bin count
interface lbp_out_if;
  logic                            valid;
  logic                            ready;
  logic                            code_valid;
  logic [lbp_pkg::BIN_W-1:0]       lbp_code;
  logic                            frame_done;
  logic [lbp_pkg::OUT_COUNT_W-1:0] bin_count;

  modport source (output valid, code_valid, lbp_code, frame_done, bin_count, input ready);
  modport sink   (input valid, code_valid, lbp_code, frame_done, bin_count, output ready);
endinterface

/* sv/lbp_front.sv */
// Front of the LBP block: accepts items, tracks frame position, keeps the
// line stores and the 3x3 window, and forms codes. Depends on lbp_pkg, lbp_stream_if.
`timescale 1ns / 1ps

module lbp_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lbp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [lbp_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  lbp_in_if.sink                           req_i,
  output logic                             task_valid_o,
  output lbp_pkg::task_t                   task_o,
  input  lbp_pkg::q_stat_t                 q_stat_i
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int RST_W = (lbp_pkg::RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : lbp_pkg::RST_WIDTH;
  localparam int RST_H = (lbp_pkg::RST_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : lbp_pkg::RST_HEIGHT;

  localparam int PW = lbp_pkg::PIX_W;

  // Configuration (held clamped)
  logic [WW-1:0] width_q;
  logic [HW-1:0] height_q;
  logic [31:0]   wdata_ext;
  logic [WW-1:0] width_clamp;
  logic [HW-1:0] height_clamp;

  // Frame position
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic [WW-1:0] col_next;
  logic [HW-1:0] row_next;
  logic          col_end;
  logic          row_end;

  // Line stores, one bank per row parity
  logic [PW-1:0] bank0_mem [MAX_WIDTH];
  logic [PW-1:0] bank1_mem [MAX_WIDTH];
  logic [PW-1:0] up_a_q;
  logic [PW-1:0] up_b_q;

  // Second stage
  logic             f1_valid_q;
  lbp_pkg::op_e     f1_op_q;
  lbp_pkg::op_e     op_d;
  logic [PW-1:0]    f1_px_q;
  logic [lbp_pkg::BIN_W-1:0] f1_bin_q;
  logic             f1_par_q;
  logic             f1_cv_q;
  logic             f1_done_q;
  logic             acc;
  logic             f1_fire;
  logic             is_pixel;

  // Window columns: [0] older, [1] newer
  logic [PW-1:0] top_q [2];
  logic [PW-1:0] mid_q [2];
  logic [PW-1:0] bot_q [2];
  logic [PW-1:0] up2;
  logic [PW-1:0] up1;
  logic [lbp_pkg::BIN_W-1:0] code;

  // Handshake: the second stage drains into the queue
  assign f1_fire     = f1_valid_q && !q_stat_i.full;
  assign req_i.ready = !f1_valid_q || !q_stat_i.full;
  assign acc         = req_i.valid && req_i.ready;
  assign is_pixel    = (req_i.command == lbp_pkg::CMD_PIXEL);

  // Clamp a configuration write
  assign wdata_ext    = 32'(cfg_wdata_i);
  assign width_clamp  = (wdata_ext < 32'(lbp_pkg::MIN_DIM)) ? WW'(lbp_pkg::MIN_DIM) :
                        (wdata_ext > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(wdata_ext);
  assign height_clamp = (wdata_ext < 32'(lbp_pkg::MIN_DIM)) ? HW'(lbp_pkg::MIN_DIM) :
                        (wdata_ext > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(wdata_ext);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WW'(RST_W);
      height_q <= HW'(RST_H);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == lbp_pkg::REG_IMAGE_WIDTH) begin
        width_q <= width_clamp;
      end else if (cfg_idx_i == lbp_pkg::REG_IMAGE_HEIGHT) begin
        height_q <= height_clamp;
      end
    end
  end

  // Position step and wrap
  assign col_next = WW'(col_q) + WW'(1);
  assign row_next = HW'(row_q) + HW'(1);
  assign col_end  = (col_next >= width_q);
  assign row_end  = (row_next >= height_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (acc) begin
      if (is_pixel) begin
        if (col_end) begin
          col_q <= '0;
          row_q <= row_end ? '0 : RW'(row_next);
        end else begin
          col_q <= CW'(col_next);
        end
      end else if (req_i.command == lbp_pkg::CMD_CLEAR) begin
        col_q <= '0;
        row_q <= '0;
      end
    end
  end

  // Line stores: read both banks, write the current row's bank
  always_ff @(posedge clk_i) begin
    if (acc && is_pixel) begin
      up_a_q <= bank0_mem[col_q];
      up_b_q <= bank1_mem[col_q];
      if (row_q[0]) begin
        bank1_mem[col_q] <= req_i.pixel;
      end else begin
        bank0_mem[col_q] <= req_i.pixel;
      end
    end
  end

  // Map the command onto an operation
  always_comb begin
    case (req_i.command)
      lbp_pkg::CMD_PIXEL:    op_d = lbp_pkg::OP_PIXEL;
      lbp_pkg::CMD_READ_BIN: op_d = lbp_pkg::OP_READ;
      lbp_pkg::CMD_CLEAR:    op_d = lbp_pkg::OP_CLEAR;
      default:               op_d = lbp_pkg::OP_NONE;
    endcase
  end

  // Second stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
    end else if (acc) begin
      f1_valid_q <= 1'b1;
    end else if (f1_fire) begin
      f1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      f1_op_q   <= op_d;
      f1_px_q   <= req_i.pixel;
      f1_bin_q  <= req_i.bin_index;
      f1_par_q  <= row_q[0];
      f1_cv_q   <= is_pixel && (row_q >= RW'(lbp_pkg::WIN_EDGE)) &&
                   (col_q >= CW'(lbp_pkg::WIN_EDGE));
      f1_done_q <= is_pixel && col_end && row_end;
    end
  end

  // Row r-2 shares the current row's bank
  assign up2 = f1_par_q ? up_b_q : up_a_q;
  assign up1 = f1_par_q ? up_a_q : up_b_q;

  assign code = lbp_pkg::form_code(top_q[0], top_q[1], up2,
                                   mid_q[0], mid_q[1], up1,
                                   bot_q[0], bot_q[1], f1_px_q);

  // Shift the window on a pixel, zero it on a clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= '{default: '0};
      mid_q <= '{default: '0};
      bot_q <= '{default: '0};
    end else if (f1_fire) begin
      if (f1_op_q == lbp_pkg::OP_PIXEL) begin
        top_q[0] <= top_q[1];
        top_q[1] <= up2;
        mid_q[0] <= mid_q[1];
        mid_q[1] <= up1;
        bot_q[0] <= bot_q[1];
        bot_q[1] <= f1_px_q;
      end else if (f1_op_q == lbp_pkg::OP_CLEAR) begin
        top_q <= '{default: '0};
        mid_q <= '{default: '0};
        bot_q <= '{default: '0};
      end
    end
  end

  // Hand the operation to the queue
  assign task_valid_o      = f1_valid_q;
  assign task_o.op         = f1_op_q;
  assign task_o.code_valid = f1_cv_q;
  assign task_o.frame_done = f1_done_q;
  assign task_o.addr       = (f1_op_q == lbp_pkg::OP_PIXEL) ? code : f1_bin_q;

endmodule

/* sv/lbp_queue.sv */
// Short operation queue between the front and the histogram side.
// Depends on lbp_pkg for the operation type and depth.
`timescale 1ns / 1ps

module lbp_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  input  lbp_pkg::task_t   push_data_i,
  output lbp_pkg::q_stat_t stat_o,
  output logic             pop_valid_o,
  output lbp_pkg::task_t   pop_data_o,
  input  logic             pop_ready_i
);

  localparam int PTR_W = $clog2(lbp_pkg::Q_DEPTH);

  lbp_pkg::task_t   entry_q [lbp_pkg::Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [PTR_W:0]   count_q;
  logic             push;
  logic             pop;

  // Full comes from the registered count alone, so the front never sees the far side's ready
  assign stat_o.full  = (count_q == (PTR_W+1)'(lbp_pkg::Q_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign push         = push_valid_i && !stat_o.full;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_valid_o  = !stat_o.empty;
  assign pop_data_o   = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + (PTR_W+1)'(1);
      end else if (pop && !push) begin
        count_q <= count_q - (PTR_W+1)'(1);
      end
    end
  end

  // Store pushed operations
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* sv/lbp_back.sv */
// Histogram side of the LBP block: saturating bin counts in a memory with
// valid bits, bin reads, clears and the result register. Depends on lbp_pkg, lbp_stream_if.
`timescale 1ns / 1ps

module lbp_back #(
  parameter int COUNT_WIDTH = 20
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  lbp_pkg::task_t head_i,
  output logic           head_ready_o,
  lbp_out_if.source      rsp_o
);

  localparam int OW = lbp_pkg::OUT_COUNT_W;

  // Histogram memory and per-bin valid bits
  logic [COUNT_WIDTH-1:0]     hist_mem [lbp_pkg::NBINS];
  logic [COUNT_WIDTH-1:0]     rdata_q;
  logic [lbp_pkg::NBINS-1:0]  vbit_q;

  // Stage holding the operation whose read data is in rdata_q
  logic                       s1_valid_q;
  lbp_pkg::task_t             s1_q;
  logic                       s1_fire;
  logic                       pop;

  // Last write, forwarded over the memory's registered read
  logic                       lwr_valid_q;
  logic [lbp_pkg::BIN_W-1:0]  lwr_addr_q;
  logic [COUNT_WIDTH-1:0]     lwr_data_q;

  logic [COUNT_WIDTH-1:0]     cur_count;
  logic [COUNT_WIDTH-1:0]     inc_count;
  logic [OW+COUNT_WIDTH-1:0]  count_ext;
  logic                       wr_en;
  logic                       is_clear;

  // Result register
  logic                       out_valid_q;
  logic                       code_valid_q;
  logic [lbp_pkg::BIN_W-1:0]  lbp_code_q;
  logic                       frame_done_q;
  logic [OW-1:0]              bin_count_q;

  assign s1_fire      = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign head_ready_o = !s1_valid_q || s1_fire;
  assign pop          = head_valid_i && head_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (head_ready_o) begin
      s1_valid_q <= head_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      s1_q <= head_i;
    end
  end

  // Current count: forwarded write, else memory if the bin is valid, else zero
  assign cur_count = (lwr_valid_q && (lwr_addr_q == s1_q.addr)) ? lwr_data_q :
                     vbit_q[s1_q.addr] ? rdata_q : '0;
  assign inc_count = cur_count + COUNT_WIDTH'(1);
  assign wr_en     = s1_fire && (s1_q.op == lbp_pkg::OP_PIXEL) && s1_q.code_valid &&
                     !(&cur_count);
  assign is_clear  = s1_fire && (s1_q.op == lbp_pkg::OP_CLEAR);
  assign count_ext = {{OW{1'b0}}, cur_count};

  // Memory: registered read on pop, write back the incremented count
  always_ff @(posedge clk_i) begin
    if (pop) begin
      rdata_q <= hist_mem[head_i.addr];
    end
    if (wr_en) begin
      hist_mem[s1_q.addr] <= inc_count;
    end
  end

  // Valid bits and forward register; a clear drops both at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vbit_q      <= '0;
      lwr_valid_q <= 1'b0;
    end else if (is_clear) begin
      vbit_q      <= '0;
      lwr_valid_q <= 1'b0;
    end else if (wr_en) begin
      vbit_q[s1_q.addr] <= 1'b1;
      lwr_valid_q       <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      lwr_addr_q <= s1_q.addr;
      lwr_data_q <= inc_count;
    end
  end

  // Result register: load on fire, drop on transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      code_valid_q <= s1_q.code_valid;
      lbp_code_q   <= s1_q.code_valid ? s1_q.addr : '0;
      frame_done_q <= s1_q.frame_done;
      bin_count_q  <= (s1_q.op == lbp_pkg::OP_READ) ? count_ext[OW-1:0] : '0;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.code_valid = code_valid_q;
  assign rsp_o.lbp_code   = lbp_code_q;
  assign rsp_o.frame_done = frame_done_q;
  assign rsp_o.bin_count  = bin_count_q;

endmodule

/* sv/lbp_code_histogram.sv */
// The block takes one item per clock while the queue has room: a pixel in raster order,
// a bin read or a clear, and returns exactly one result per item, in order. A pixel at
// row and column two or more yields the 8-neighbour local binary pattern of the pixel
// above-left of it and bumps that code's saturating bin; the last pixel of a frame raises
// frame_done. Throughput is one item per cycle when nothing stalls, set by one read and
// one write per line-store bank and a histogram read-modify-write with a forwarded last
// write. An item is registered in the front's second stage, the queue, the histogram stage
// and the result register. Width and height are clamped to 3..MAX_WIDTH and 3..MAX_HEIGHT
// when written; the user must write them only while idle: the block does not enforce it.
// Depends on lbp_pkg, lbp_stream_if, lbp_front, lbp_queue, lbp_back.
`timescale 1ns / 1ps
`include "lbp_code_histogram_defines.svh"

module lbp_code_histogram #(
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_HEIGHT  = 1024,
  parameter int COUNT_WIDTH = 20
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lbp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lbp_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  lbp_in_if.sink                         req_i,
  lbp_out_if.source                      rsp_o
);

  logic             f_task_valid;
  lbp_pkg::task_t   f_task;
  lbp_pkg::q_stat_t q_stat;
  logic             q_head_valid;
  lbp_pkg::task_t   q_head;
  logic             q_head_ready;

  // Accept, position, line stores, window and code forming
  lbp_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req_i        (req_i),
    .task_valid_o (f_task_valid),
    .task_o       (f_task),
    .q_stat_i     (q_stat)
  );

  // Decouple the two sides
  lbp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_task_valid),
    .push_data_i  (f_task),
    .stat_o       (q_stat),
    .pop_valid_o  (q_head_valid),
    .pop_data_o   (q_head),
    .pop_ready_i  (q_head_ready)
  );

  // Histogram update, bin reads, clears and results
  lbp_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_head_valid),
    .head_i       (q_head),
    .head_ready_o (q_head_ready),
    .rsp_o        (rsp_o)
  );

  // A bin count only ever comes back on a read, never with a code or frame end
  `LBP_ASSERT_IMP(a_count_alone, rsp_o.valid && (rsp_o.bin_count != '0), !rsp_o.code_valid && !rsp_o.frame_done, "bin count returned with a pixel result")
  // No code value without a completed window
  `LBP_ASSERT_IMP(a_code_flagged, rsp_o.valid && !rsp_o.code_valid, rsp_o.lbp_code == '0, "code value without a completed window")
  // The front holds off only when the queue is full
  `LBP_ASSERT_IMP(a_ready_cause, !req_i.ready, q_stat.full, "input held off with room in the queue")
  // An operation pushed into the queue leaves it non-empty
  `LBP_ASSERT_NEXT(a_push_lands, f_task_valid && !q_stat.full, !q_stat.empty, "pushed operation lost in the queue")

endmodule
